// ----- rtl/zmbp_pkg.sv -----
// ----------------------------------------------------------------------------
// zmbp_pkg - zone map block pruner package
// Shared widths, codes, state type and comparator result type.
// ----------------------------------------------------------------------------
package zmbp_pkg;

	localparam int MAX_KEYS = 64;
	localparam int KEY_AW   = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);

	localparam int VAL_W      = 64;
	localparam int ACTION_W   = 2;
	localparam int KEY_IDX_W  = 6;
	localparam int ROWS_W     = 32;
	localparam int STRAT_W    = 3;
	localparam int KEY_CNT_W  = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CLASS_W    = 2;

	localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BLOCK = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POINT = 2'd2;

	localparam logic [STRAT_W-1:0] STRAT_LT = 3'd0;
	localparam logic [STRAT_W-1:0] STRAT_LE = 3'd1;
	localparam logic [STRAT_W-1:0] STRAT_EQ = 3'd2;
	localparam logic [STRAT_W-1:0] STRAT_GE = 3'd3;
	localparam logic [STRAT_W-1:0] STRAT_GT = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARGUMENT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARG_NULL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ARRAY_EN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 3'd4;

	localparam logic [CLASS_W-1:0] MC_NONE  = 2'd0;
	localparam logic [CLASS_W-1:0] MC_MAYBE = 2'd1;
	localparam logic [CLASS_W-1:0] MC_FULL  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_ARG_HI,
		ST_ARG_LO,
		ST_RNG_FIRST,
		ST_RNG_LAST,
		ST_RNG_ORDER,
		ST_RNG_HI,
		ST_RNG_LO,
		ST_BS_STEP,
		ST_BS_LAST
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

// ----- rtl/zmbp_ram.sv -----
// ----------------------------------------------------------------------------
// zmbp_ram - generic single write, single read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module zmbp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/zmbp_cmp.sv -----
// ----------------------------------------------------------------------------
// zmbp_cmp - shared signed comparator
// Signed 64-bit less-than and equality, shared by all the sequencer's compare steps.
// ----------------------------------------------------------------------------
module zmbp_cmp (
	input  logic signed [zmbp_pkg::VAL_W-1:0] a,
	input  logic signed [zmbp_pkg::VAL_W-1:0] b,
	output zmbp_pkg::cmp_res_t                res
);
	import zmbp_pkg::*;

	always_comb begin
		res.lt = a < b;
		res.eq = a == b;
	end

endmodule

// ----- rtl/zone_map_block_pruner.sv -----
// ----------------------------------------------------------------------------
// zone_map_block_pruner - zone map min/max block pruning
// Classifies a block against a scan predicate or a sorted key list, and
// tests single point values.
//
//   channel   ports                                   handshake
//   item in   action, key_*, block_*, point_value     start & !busy
//   result    match_class, point_match                done, one cycle
//   config    cfg_index, cfg_data                     cfg_we
//
// Key load or unused action: busy stays low.
// Normal mode: busy through ST_ARG_HI and ST_ARG_LO, result the cycle after.
// Key list range test: busy in ST_SPLIT, then ST_RNG_FIRST through ST_RNG_LO.
// Key list search: busy in ST_SPLIT, ST_BS_STEP and ST_BS_LAST, with one key RAM
// read and one 64-bit compare per step.
// Reset clears control and config; the key store keeps no reset. The
// receiver cannot stall; a new item can already be taken in the cycle done is high.
// ----------------------------------------------------------------------------
module zone_map_block_pruner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [zmbp_pkg::ACTION_W-1:0]       action,
	input  logic [zmbp_pkg::KEY_IDX_W-1:0]      key_index,
	input  logic signed [zmbp_pkg::VAL_W-1:0]   key_value,
	input  logic signed [zmbp_pkg::VAL_W-1:0]   block_min,
	input  logic signed [zmbp_pkg::VAL_W-1:0]   block_max,
	input  logic [zmbp_pkg::ROWS_W-1:0]         block_row_count,
	input  logic [zmbp_pkg::ROWS_W-1:0]         block_null_count,
	input  logic signed [zmbp_pkg::VAL_W-1:0]   point_value,
	input  logic                                cfg_we,
	input  logic [zmbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [zmbp_pkg::VAL_W-1:0]          cfg_data,
	output logic                                done,
	output logic [zmbp_pkg::CLASS_W-1:0]        match_class,
	output logic                                point_match
);
	import zmbp_pkg::*;

	state_t state_q, state_d;

	logic [STRAT_W-1:0]       strategy_q;
	logic signed [VAL_W-1:0]  argument_q;
	logic                     arg_null_q;
	logic                     array_en_q;
	logic [KEY_CNT_W-1:0]     key_count_q;

	logic signed [VAL_W-1:0]  mn_q, mx_q, lo_q, hi_q;
	logic                     rows_nz_q, nulls_nz_q, is_point_q;
	logic                     mxlt_q, mxeq_q, ok_q;
	logic [CNT_W-1:0]         blo_q, bhi_q, mid_q;

	logic                     done_q, pm_q;
	logic [CLASS_W-1:0]       mc_q;

	logic                     accept;
	logic [CNT_W-1:0]         n_len, n_m1, nlo, nhi, half_n, nmid;
	logic [CNT_W:0]           idx_sum;
	logic [KEY_AW-1:0]        raddr;
	logic [VAL_W-1:0]         rdata;
	logic signed [VAL_W-1:0]  key_rd;
	logic signed [VAL_W-1:0]  op_a, op_b;
	cmp_res_t                 cres;
	logic                     ram_we;
	logic [CLASS_W-1:0]       full_cls, norm_cls;
	logic                     norm_pm, found;

	assign accept = start && !busy;
	assign busy   = state_q != ST_IDLE;
	assign ram_we = accept && action == ACT_LOAD && int'(key_index) < MAX_KEYS;
	assign key_rd = $signed(rdata);

	assign n_len  = (int'(key_count_q) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count_q);
	assign n_m1   = n_len - CNT_W'(1);
	assign half_n = n_len >> 1;

	// lower bound search step
	assign nlo     = cres.lt ? mid_q + CNT_W'(1) : blo_q;
	assign nhi     = cres.lt ? bhi_q : mid_q;
	assign idx_sum = {1'b0, nlo} + {1'b0, nhi};
	assign nmid    = idx_sum[CNT_W:1];

	zmbp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_KEYS)
	) u_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (KEY_AW'(key_index)),
		.wdata (key_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	zmbp_cmp u_cmp (
		.a   (op_a),
		.b   (op_b),
		.res (cres)
	);

	always_comb begin
		unique case (state_q)
			ST_ARG_HI:    begin op_a = mx_q;   op_b = argument_q; end
			ST_ARG_LO:    begin op_a = mn_q;   op_b = argument_q; end
			ST_RNG_ORDER: begin op_a = hi_q;   op_b = lo_q;       end
			ST_RNG_HI:    begin op_a = hi_q;   op_b = mn_q;       end
			ST_RNG_LO:    begin op_a = mx_q;   op_b = lo_q;       end
			ST_BS_STEP:   begin op_a = key_rd; op_b = mn_q;       end
			ST_BS_LAST:   begin op_a = mn_q;   op_b = key_rd;     end
			default:      begin op_a = mn_q;   op_b = mx_q;       end
		endcase
	end

	// normal mode classification, cres holds mn against argument
	always_comb begin
		full_cls = nulls_nz_q ? MC_MAYBE : MC_FULL;
		norm_cls = MC_NONE;
		norm_pm  = 1'b0;
		unique case (strategy_q)
			STRAT_LT: begin
				norm_cls = mxlt_q ? full_cls : cres.lt ? MC_MAYBE : MC_NONE;
				norm_pm  = cres.lt;
			end
			STRAT_LE: begin
				norm_cls = (mxlt_q || mxeq_q) ? full_cls :
					(cres.lt || cres.eq) ? MC_MAYBE : MC_NONE;
				norm_pm  = cres.lt || cres.eq;
			end
			STRAT_EQ: begin
				norm_cls = (cres.eq && mxeq_q) ? full_cls :
					((cres.lt || cres.eq) && !mxlt_q) ? MC_MAYBE : MC_NONE;
				norm_pm  = cres.eq;
			end
			STRAT_GE: begin
				norm_cls = !cres.lt ? full_cls : !mxlt_q ? MC_MAYBE : MC_NONE;
				norm_pm  = !cres.lt;
			end
			STRAT_GT: begin
				norm_cls = (!cres.lt && !cres.eq) ? full_cls :
					(!mxlt_q && !mxeq_q) ? MC_MAYBE : MC_NONE;
				norm_pm  = !cres.lt && !cres.eq;
			end
			default: begin
				norm_cls = MC_NONE;
				norm_pm  = 1'b0;
			end
		endcase
		if (arg_null_q || (!is_point_q && !rows_nz_q)) begin
			norm_cls = MC_NONE;
			norm_pm  = 1'b0;
		end
		if (is_point_q) begin
			norm_cls = MC_NONE;
		end else begin
			norm_pm = 1'b0;
		end
	end

	assign found = (blo_q < n_len) && !cres.lt;

	always_comb begin
		state_d = state_q;
		raddr   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (action == ACT_BLOCK || action == ACT_POINT)) begin
					state_d = array_en_q ? ST_SPLIT : ST_ARG_HI;
				end
			end
			ST_SPLIT: begin
				if (cres.eq) begin
					raddr   = half_n[KEY_AW-1:0];
					state_d = (n_len != '0) ? ST_BS_STEP : ST_BS_LAST;
				end else begin
					state_d = ST_RNG_FIRST;
				end
			end
			ST_ARG_HI:    state_d = ST_ARG_LO;
			ST_ARG_LO:    state_d = ST_IDLE;
			ST_RNG_FIRST: begin
				raddr   = n_m1[KEY_AW-1:0];
				state_d = ST_RNG_LAST;
			end
			ST_RNG_LAST:  state_d = ST_RNG_ORDER;
			ST_RNG_ORDER: state_d = ST_RNG_HI;
			ST_RNG_HI:    state_d = ST_RNG_LO;
			ST_RNG_LO:    state_d = ST_IDLE;
			ST_BS_STEP: begin
				if (nlo < nhi) begin
					raddr = nmid[KEY_AW-1:0];
				end else begin
					raddr   = nlo[KEY_AW-1:0];
					state_d = ST_BS_LAST;
				end
			end
			ST_BS_LAST:   state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q  <= STRAT_EQ;
			argument_q  <= '0;
			arg_null_q  <= 1'b0;
			array_en_q  <= 1'b0;
			key_count_q <= KEY_CNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRATEGY:  strategy_q  <= cfg_data[STRAT_W-1:0];
				REG_ARGUMENT:  argument_q  <= $signed(cfg_data);
				REG_ARG_NULL:  arg_null_q  <= cfg_data[0];
				REG_ARRAY_EN:  array_en_q  <= cfg_data[0];
				REG_KEY_COUNT: key_count_q <= cfg_data[KEY_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= state_q == ST_ARG_LO || state_q == ST_RNG_LO ||
				state_q == ST_BS_LAST;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					is_point_q <= action == ACT_POINT;
					mn_q       <= (action == ACT_POINT) ? point_value : block_min;
					mx_q       <= (action == ACT_POINT) ? point_value : block_max;
					rows_nz_q  <= block_row_count != '0;
					nulls_nz_q <= block_null_count != '0;
				end
			end
			ST_SPLIT: begin
				blo_q <= '0;
				bhi_q <= n_len;
				mid_q <= half_n;
			end
			ST_ARG_HI: begin
				mxlt_q <= cres.lt;
				mxeq_q <= cres.eq;
			end
			ST_ARG_LO: begin
				mc_q <= norm_cls;
				pm_q <= norm_pm;
			end
			ST_RNG_FIRST: lo_q <= key_rd;
			ST_RNG_LAST:  hi_q <= key_rd;
			ST_RNG_ORDER: begin
				if (cres.lt) begin
					lo_q <= hi_q;
					hi_q <= lo_q;
				end
			end
			ST_RNG_HI: ok_q <= !cres.lt;
			ST_RNG_LO: begin
				mc_q <= (ok_q && !cres.lt && rows_nz_q && n_len != '0) ? MC_MAYBE : MC_NONE;
				pm_q <= 1'b0;
			end
			ST_BS_STEP: begin
				blo_q <= nlo;
				bhi_q <= nhi;
				mid_q <= nmid;
			end
			ST_BS_LAST: begin
				if (is_point_q) begin
					mc_q <= MC_NONE;
					pm_q <= found;
				end else begin
					mc_q <= (found && rows_nz_q) ?
						(nulls_nz_q ? MC_MAYBE : MC_FULL) : MC_NONE;
					pm_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign match_class = mc_q;
	assign point_match = pm_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a busy cycle before it");

	a_query_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_BLOCK || action == ACT_POINT)) |=> busy)
		else $error("query item accepted but sequencer idle");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_LOAD) |=> !busy && !done)
		else $error("key load started the sequencer");

	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (match_class == MC_NONE || match_class == MC_MAYBE ||
			match_class == MC_FULL))
		else $error("match class out of range");

	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		(done && match_class != MC_NONE) |-> !point_match)
		else $error("block and point results both set");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BS_STEP) |-> (blo_q < bhi_q && mid_q < bhi_q))
		else $error("search window empty while stepping");

endmodule

// ----- sim/zone_map_block_pruner_tb.sv -----
// ----------------------------------------------------------------------------
// zone_map_block_pruner_tb - testbench for the zone map block pruner
// Drives key loads, block classifications and point tests through the
// start/busy port under several register settings. Each accepted item is
// fed to a software copy of the pruner, and every done strobe is checked
// field by field against the oldest predicted verdict.
// ----------------------------------------------------------------------------
import zmbp_pkg::*;

typedef logic signed [VAL_W-1:0] val_t;

typedef struct packed {
	logic [ACTION_W-1:0]  action;
	logic [KEY_IDX_W-1:0] key_index;
	val_t                 key_value;
	val_t                 block_min;
	val_t                 block_max;
	logic [ROWS_W-1:0]    row_count;
	logic [ROWS_W-1:0]    null_count;
	val_t                 point_value;
} scan_req_t;

typedef struct packed {
	logic [CLASS_W-1:0] match_class;
	logic               point_match;
} verdict_t;

class verdict_book;
	logic [STRAT_W-1:0]   strategy;
	val_t                 argument;
	logic                 arg_null;
	logic                 array_en;
	logic [KEY_CNT_W-1:0] key_count;
	val_t                 keys [MAX_KEYS];
	verdict_t             pending [$];
	int                   failures;

	function new();
		strategy  = STRAT_EQ;
		argument  = '0;
		arg_null  = 1'b0;
		array_en  = 1'b0;
		key_count = KEY_CNT_W'(1);
		failures  = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		case (idx)
			REG_STRATEGY:  strategy  = data[STRAT_W-1:0];
			REG_ARGUMENT:  argument  = data;
			REG_ARG_NULL:  arg_null  = data[0];
			REG_ARRAY_EN:  array_en  = data[0];
			REG_KEY_COUNT: key_count = data[KEY_CNT_W-1:0];
			default: ;
		endcase
	endfunction

	function int list_len();
		return (key_count > MAX_KEYS) ? MAX_KEYS : int'(key_count);
	endfunction

	// lower-bound search; also defined for unsorted lists
	function bit list_holds(val_t v);
		int n, lo, hi, mid;
		n  = list_len();
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (keys[mid] < v)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo >= n)
			return 1'b0;
		return !(v < keys[lo]);
	endfunction

	function logic [CLASS_W-1:0] block_class(scan_req_t r);
		logic [CLASS_W-1:0] full;
		val_t mn, mx, a, lo, hi, t;
		int n;
		mn = r.block_min;
		mx = r.block_max;
		a  = argument;
		if (r.row_count == 0)
			return MC_NONE;
		full = (r.null_count != 0) ? MC_MAYBE : MC_FULL;
		if (array_en) begin
			n = list_len();
			if (n == 0)
				return MC_NONE;
			if (mn != mx) begin
				lo = keys[0];
				hi = keys[n-1];
				if (hi < lo) begin
					t  = lo;
					lo = hi;
					hi = t;
				end
				return (mn <= hi && mx >= lo) ? MC_MAYBE : MC_NONE;
			end
			return list_holds(mn) ? full : MC_NONE;
		end
		if (arg_null)
			return MC_NONE;
		case (strategy)
			STRAT_LT: return (mx < a) ? full : (mn < a) ? MC_MAYBE : MC_NONE;
			STRAT_LE: return (mx <= a) ? full : (mn <= a) ? MC_MAYBE : MC_NONE;
			STRAT_EQ: begin
				if (mn == a && mx == a)
					return full;
				return (mn <= a && mx >= a) ? MC_MAYBE : MC_NONE;
			end
			STRAT_GE: return (mn >= a) ? full : (mx >= a) ? MC_MAYBE : MC_NONE;
			STRAT_GT: return (mn > a) ? full : (mx > a) ? MC_MAYBE : MC_NONE;
			default:  return MC_NONE;
		endcase
	endfunction

	function logic point_hit(val_t v);
		if (array_en)
			return list_holds(v);
		if (arg_null)
			return 1'b0;
		case (strategy)
			STRAT_LT: return v < argument;
			STRAT_LE: return v <= argument;
			STRAT_EQ: return v == argument;
			STRAT_GE: return v >= argument;
			STRAT_GT: return v > argument;
			default:  return 1'b0;
		endcase
	endfunction

	function void note_item(scan_req_t r);
		verdict_t v;
		case (r.action)
			ACT_LOAD: keys[r.key_index] = r.key_value;
			ACT_BLOCK: begin
				v.match_class = block_class(r);
				v.point_match = 1'b0;
				pending.insert(pending.size(), v);
			end
			ACT_POINT: begin
				v.match_class = MC_NONE;
				v.point_match = point_hit(r.point_value);
				pending.insert(pending.size(), v);
			end
			default: ;
		endcase
	endfunction

	function void report(string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endfunction

	function void check_verdict(logic [CLASS_W-1:0] mc, logic pm);
		verdict_t e;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result: match_class %0d point_match %0d", mc, pm));
			return;
		end
		e = pending.pop_front();
		if (mc !== e.match_class)
			report($sformatf("match_class mismatch: expected %0d, got %0d",
				e.match_class, mc));
		if (pm !== e.point_match)
			report($sformatf("point_match mismatch: expected %0d, got %0d",
				e.point_match, pm));
	endfunction

	function void drain_check();
		if (pending.size() != 0)
			report($sformatf("%0d results never arrived", pending.size()));
	endfunction
endclass

module zone_map_block_pruner_tb;

	localparam int   CYCLE_LIMIT  = 600000;
	localparam int   RANDOM_ITEMS = 900;
	localparam int   SETTLE       = 16;
	localparam val_t VAL_MIN      = {1'b1, {(VAL_W-1){1'b0}}};
	localparam val_t VAL_MAX      = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [STRAT_W-1:0]  STRAT_UNDEF = 3'd7;
	localparam logic [ACTION_W-1:0] ACT_SPARE   = 2'd3;

	logic                 clk              = 1'b0;
	logic                 arst_n           = 1'b0;
	logic                 start            = 1'b0;
	logic                 busy;
	logic [ACTION_W-1:0]  action           = ACT_LOAD;
	logic [KEY_IDX_W-1:0] key_index        = '0;
	val_t                 key_value        = '0;
	val_t                 block_min        = '0;
	val_t                 block_max        = '0;
	logic [ROWS_W-1:0]    block_row_count  = '0;
	logic [ROWS_W-1:0]    block_null_count = '0;
	val_t                 point_value      = '0;
	logic                 cfg_we           = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index        = '0;
	logic [VAL_W-1:0]     cfg_data         = '0;
	logic                 done;
	logic [CLASS_W-1:0]   match_class;
	logic                 point_match;

	verdict_book book;
	bit          written [MAX_KEYS];
	int          gap_mode     = 1;
	int          random_items = 0;
	int          cycles       = 0;

	zone_map_block_pruner i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.key_index        (key_index),
		.key_value        (key_value),
		.block_min        (block_min),
		.block_max        (block_max),
		.block_row_count  (block_row_count),
		.block_null_count (block_null_count),
		.point_value      (point_value),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.match_class      (match_class),
		.point_match      (point_match)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			book.check_verdict(match_class, point_match);
	end

	function automatic val_t rand_val();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gap_mode == 0 || r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96 || gap_mode == 1)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// values near the argument, the key list, zero and the extremes, or random
	function automatic val_t pick_value();
		int k;
		k = $urandom_range(0, MAX_KEYS-1);
		case ($urandom_range(0, 9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return val_t'(int'($urandom_range(0, 8)) - 4);
			3, 4:    return book.argument + val_t'(int'($urandom_range(0, 2)) - 1);
			5, 6:    return written[k] ? book.keys[k] + val_t'(int'($urandom_range(0, 2)) - 1)
			                           : rand_val();
			default: return rand_val();
		endcase
	endfunction

	function automatic bit prefix_written(int n);
		for (int i = 0; i < n; i++)
			if (!written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic scan_req_t rand_req(logic [ACTION_W-1:0] act);
		scan_req_t r;
		r.action      = act;
		r.key_index   = KEY_IDX_W'($urandom);
		r.key_value   = rand_val();
		r.block_min   = rand_val();
		r.block_max   = rand_val();
		r.row_count   = $urandom;
		r.null_count  = $urandom;
		r.point_value = rand_val();
		return r;
	endfunction

	task automatic send_item(scan_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action           <= r.action;
		key_index        <= r.key_index;
		key_value        <= r.key_value;
		block_min        <= r.block_min;
		block_max        <= r.block_max;
		block_row_count  <= r.row_count;
		block_null_count <= r.null_count;
		point_value      <= r.point_value;
		start            <= 1'b1;
		do @(posedge clk); while (busy);
		book.note_item(r);
		random_items++;
		if (r.action == ACT_LOAD)
			written[r.key_index] = 1'b1;
	endtask

	task automatic load_key(int idx, val_t v);
		scan_req_t r;
		r           = rand_req(ACT_LOAD);
		r.key_index = KEY_IDX_W'(idx);
		r.key_value = v;
		send_item(r);
	endtask

	task automatic block_q(val_t mn, val_t mx, logic [ROWS_W-1:0] rows,
		logic [ROWS_W-1:0] nulls);
		scan_req_t r;
		r            = rand_req(ACT_BLOCK);
		r.block_min  = mn;
		r.block_max  = mx;
		r.row_count  = rows;
		r.null_count = nulls;
		send_item(r);
	endtask

	task automatic point_q(val_t v);
		scan_req_t r;
		r             = rand_req(ACT_POINT);
		r.point_value = v;
		send_item(r);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		book.write_reg(idx, data);
	endtask

	task automatic configure(logic [STRAT_W-1:0] strat, val_t arg, logic anull,
		logic arr, logic [KEY_CNT_W-1:0] kc);
		settle();
		put_reg(REG_STRATEGY, strat);
		put_reg(REG_ARGUMENT, arg);
		put_reg(REG_ARG_NULL, anull);
		put_reg(REG_ARRAY_EN, arr);
		put_reg(REG_KEY_COUNT, kc);
		cfg_we <= 1'b0;
	endtask

	task automatic load_list(int len, bit sorted);
		val_t             v;
		logic [VAL_W-1:0] stride;
		v = ($urandom_range(0, 3) == 0) ? VAL_MIN : pick_value();
		for (int i = 0; i < len; i++) begin
			load_key(i, sorted ? v : rand_val());
			stride = ($urandom_range(0, 15) == 0) ? VAL_W'({2'b00, rand_val()} >> 2)
			                                     : VAL_W'(1 << $urandom_range(0, 20)) - 1;
			if (v > VAL_MAX - val_t'(stride))
				v = VAL_MAX;
			else
				v = v + val_t'(stride);
		end
	endtask

	task automatic random_phase();
		logic [STRAT_W-1:0]   strat;
		logic [KEY_CNT_W-1:0] kc;
		logic [ROWS_W-1:0]    rows, nulls;
		logic                 anull, arr;
		val_t                 a, b, t;
		int                   need, r;
		arr   = ($urandom_range(0, 9) < 4);
		strat = ($urandom_range(0, 9) == 0) ? STRAT_W'($urandom_range(5, 7))
		                                    : STRAT_W'($urandom_range(0, 4));
		a     = pick_value();
		anull = ($urandom_range(0, 7) == 0);
		r     = $urandom_range(0, 19);
		kc    = (r == 0) ? KEY_CNT_W'(0) : (r == 1) ? KEY_CNT_W'(MAX_KEYS) :
		        (r == 2) ? KEY_CNT_W'($urandom_range(MAX_KEYS + 1, 127)) :
		        (r < 6)  ? KEY_CNT_W'($urandom_range(13, MAX_KEYS - 1)) :
		                   KEY_CNT_W'($urandom_range(1, 12));
		gap_mode = $urandom_range(0, 2);
		configure(strat, a, anull, arr, kc);
		need = (kc > MAX_KEYS) ? MAX_KEYS : int'(kc);
		if (!prefix_written(need) || (arr && $urandom_range(0, 1)))
			load_list((need == 0) ? $urandom_range(1, 8) : need, $urandom_range(0, 5) != 0);
		repeat ($urandom_range(10, 40)) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				a = pick_value();
				b = ($urandom_range(0, 2) == 0) ? a : pick_value();
				if (b < a && $urandom_range(0, 9) != 0) begin
					t = a;
					a = b;
					b = t;
				end
				r     = $urandom_range(0, 7);
				rows  = (r == 0) ? '0 : (r < 3) ? ROWS_W'($urandom_range(1, 4)) : $urandom;
				nulls = $urandom_range(0, 1) ? '0 : $urandom;
				block_q(a, b, rows, nulls);
			end else if (r < 88) begin
				point_q(pick_value());
			end else if (r < 95) begin
				load_key($urandom_range(0, MAX_KEYS-1), pick_value());
			end else begin
				send_item(rand_req(ACT_SPARE));
			end
		end
	endtask

	initial begin
		book = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// settings after reset: equality against zero
		block_q(VAL_MIN, VAL_MAX, 1, 0);
		block_q(0, 0, '1, 0);
		block_q(0, 0, 1, '1);
		block_q(-3, 3, 0, 0);
		point_q(0);
		point_q(VAL_MIN);
		send_item(rand_req(ACT_SPARE));

		configure(STRAT_LT, VAL_MAX, 1'b0, 1'b0, 1);
		block_q(VAL_MIN, VAL_MAX - 1, 5, 0);
		point_q(VAL_MAX);
		configure(STRAT_GT, VAL_MIN, 1'b0, 1'b0, 1);
		block_q(VAL_MIN, VAL_MAX, 5, 2);
		point_q(VAL_MIN);
		configure(STRAT_LE, -1, 1'b0, 1'b0, 1);
		block_q(-1, 1, 3, 0);
		configure(STRAT_GE, 1, 1'b0, 1'b0, 1);
		point_q(1);
		configure(STRAT_UNDEF, 0, 1'b0, 1'b0, 1);
		block_q(0, 0, 1, 0);
		point_q(0);
		configure(STRAT_EQ, 0, 1'b1, 1'b0, 1);
		block_q(0, 0, 1, 0);
		point_q(0);

		// key list mode
		configure(STRAT_EQ, 0, 1'b0, 1'b1, 4);
		load_key(0, VAL_MIN);
		load_key(1, -5);
		load_key(2, 7);
		load_key(3, VAL_MAX);
		block_q(7, 7, 1, 0);
		block_q(8, 8, 1, 0);
		block_q(-100, 100, 1, 1);
		point_q(VAL_MAX);
		point_q(6);
		configure(STRAT_EQ, 0, 1'b0, 1'b1, 0);
		block_q(7, 7, 1, 0);
		point_q(7);

		while (random_items < RANDOM_ITEMS)
			random_phase();

		settle();
		book.drain_check();
		if (book.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
